@@ rtl/abfs_pkg.sv @@
// ----------------------------------------------------------------------------
// abfs_pkg
// Shared types and constants for the audio block frame splitter.
// ----------------------------------------------------------------------------
package abfs_pkg;

  localparam int unsigned SectorW = 20;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned WindowW = 32;
  localparam int unsigned HdrCntW = 3;
  localparam int unsigned FrameW  = 16;

  localparam logic [SectorW-1:0] SectorSizeReset = 20'h4E000;
  localparam logic [WindowW-1:0] PadMarker       = 32'hFFFF_FFFF;
  localparam logic [FrameW-1:0]  KeyBit          = 16'h8000;
  localparam logic [FrameW-1:0]  LenMask         = 16'h7FFF;
  localparam logic [HdrCntW-1:0] HdrBytes        = 3'd4;
  // whole length counts 8 more than the field, the header takes 4 of them
  localparam logic [FrameW-1:0]  LenAdjust       = 16'd4;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             frame_last;
    logic             key_mark;
  } abfs_result_t;

endpackage

@@ rtl/abfs_parser.sv @@
// ----------------------------------------------------------------------------
// abfs_parser
// Header tracking, frame countdown, pad skip: one byte per advance_i cycle.
// ----------------------------------------------------------------------------
module abfs_parser
  import abfs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  logic [ByteW-1:0]    data_byte_i,
  input  logic [SectorW-1:0]  sector_size_i,
  output abfs_result_t        result_o
);

  logic [WindowW-1:0] window_q, window_d;
  logic [HdrCntW-1:0] hdr_cnt_q, hdr_cnt_d, hdr_cnt_inc;
  logic [FrameW-1:0]  remain_q, remain_d, remain_dec;
  logic [SectorW-1:0] skip_q, skip_d;
  logic               key_q, key_d;
  logic [SectorW-1:0] offset_q, offset_d, offset_inc;

  logic [FrameW-1:0]    swapped;
  logic signed [21:0]   first_pos, first_wrap, skip_raw;
  logic [SectorW-1:0]   pad_skip;

  // offset of the marker's first byte, wrapped back into the sector
  always_comb begin
    first_pos  = $signed({2'b00, offset_q}) - 22'sd3;
    first_wrap = (first_pos < 0) ? first_pos + $signed({2'b00, sector_size_i})
                                 : first_pos;
    skip_raw   = $signed({2'b00, sector_size_i}) - first_wrap - 22'sd4;
    pad_skip   = (skip_raw < 0) ? '0 : skip_raw[SectorW-1:0];
  end

  assign swapped     = {window_d[7:0], window_d[15:8]};
  assign hdr_cnt_inc = hdr_cnt_q + 3'd1;
  assign remain_dec  = remain_q - 16'd1;
  assign offset_inc  = offset_q + 20'd1;

  always_comb begin
    window_d  = {window_q[WindowW-ByteW-1:0], data_byte_i};
    hdr_cnt_d = hdr_cnt_q;
    remain_d  = remain_q;
    skip_d    = skip_q;
    key_d     = key_q;
    offset_d  = (offset_inc >= sector_size_i) ? '0 : offset_inc;

    result_o.out_byte   = data_byte_i;
    result_o.frame_last = 1'b0;
    result_o.key_mark   = 1'b0;

    priority if (skip_q != '0) begin
      skip_d = skip_q - 20'd1;
    end else if (remain_q == '0) begin
      hdr_cnt_d = hdr_cnt_inc;
      if (hdr_cnt_inc >= HdrBytes) begin
        hdr_cnt_d = '0;
        if (window_d == PadMarker) begin
          skip_d = pad_skip;
          key_d  = 1'b0;
        end else begin
          key_d    = ((swapped & KeyBit) == '0);
          remain_d = (swapped & LenMask) + LenAdjust;
        end
      end
    end else begin
      remain_d = remain_dec;
      if (remain_dec == '0) begin
        result_o.frame_last = 1'b1;
        result_o.key_mark   = key_q;
        hdr_cnt_d           = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q  <= '0;
      hdr_cnt_q <= '0;
      remain_q  <= '0;
      skip_q    <= '0;
      key_q     <= 1'b0;
      offset_q  <= '0;
    end else if (advance_i) begin
      window_q  <= window_d;
      hdr_cnt_q <= hdr_cnt_d;
      remain_q  <= remain_d;
      skip_q    <= skip_d;
      key_q     <= key_d;
      offset_q  <= offset_d;
    end
  end

endmodule

@@ rtl/audio_block_frame_splitter.sv @@
// ----------------------------------------------------------------------------
// audio_block_frame_splitter
// Passes a byte stream through and marks the last byte of each frame.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  s_axis   | in        | tdata[7:0] data_byte
//  m_axis   | out       | tdata[7:0] out_byte, tlast frame_last, tuser key_mark
//  apb      | in/out    | reg 0 at 0x0: sector_size[19:0]
//
// One item per cycle unless m_axis stalls; accepted items go to the output register.
// The output register frees on the same edge it is taken, so a stall on m_axis
// holds s_axis_tready low only while a result is waiting and m_axis_tready is low.
// Reset clears all parser state and sets sector_size to 0x4E000.
// ----------------------------------------------------------------------------
module audio_block_frame_splitter
  import abfs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,   // [0] key_mark
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic RegSectorSize = 1'b0;

  logic [SectorW-1:0] sector_size_q;
  logic               out_valid_q;
  abfs_result_t       out_q, result;
  logic               accept;
  logic               reg_idx;

  assign reg_idx = paddr[2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sector_size_q <= SectorSizeReset;
    end else if (psel && penable && pwrite && (reg_idx == RegSectorSize)) begin
      sector_size_q <= pwdata[SectorW-1:0];
    end
  end

  assign prdata = (reg_idx == RegSectorSize) ? {{(32-SectorW){1'b0}}, sector_size_q}
                                             : '0;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  abfs_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (accept),
    .data_byte_i  (s_axis_tdata),
    .sector_size_i(sector_size_q),
    .result_o     (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // hold the result until taken
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.out_byte;
  assign m_axis_tlast  = out_q.frame_last;
  assign m_axis_tuser  = out_q.key_mark;

endmodule
